// ===== rtl/bankers_safety_check_core_defines.svh =====
// Assertion macros used by the safety check sequencer
`ifndef BANKERS_SAFETY_CHECK_CORE_DEFINES_SVH
`define BANKERS_SAFETY_CHECK_CORE_DEFINES_SVH

`ifndef SYNTH
`define BSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bsc: implication check failed");
`define BSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bsc: next-cycle check failed");
`else
`define BSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define BSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/bsc_pkg.sv =====
// Types, constants and helper functions of the banker's safety check
package bsc_pkg;

    localparam int MAX_PROCS  = 16;
    localparam int MAX_RES    = 16;
    localparam int PROC_LIMIT = (MAX_PROCS < 16) ? MAX_PROCS : 16;
    localparam int RES_LIMIT  = (MAX_RES < 16) ? MAX_RES : 16;
    localparam int SLOTS      = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int AMT_W      = 16;
    localparam int WORK_W     = 21;
    localparam int TBL_DEPTH  = MAX_PROCS * MAX_RES;
    localparam int ADDR_W     = $clog2(TBL_DEPTH);

    typedef logic [AMT_W-1:0]  t_amount;
    typedef logic [WORK_W-1:0] t_work;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_CLAIM = 2'd1,
        OP_AVAIL = 2'd2,
        OP_START = 2'd3
    } t_opcode;

    typedef enum logic [0:0] {
        CFG_NUM_PROCS = 1'b0,
        CFG_NUM_RES   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic  en;
        t_addr addr;
    } t_rd_req;

    function automatic t_cnt clamp_count(input t_cnt v, input int limit);
        t_cnt lim;
        lim = t_cnt'(limit);
        if (v == '0) begin
            return t_cnt'(1);
        end else if (v > lim) begin
            return lim;
        end
        return v;
    endfunction

    function automatic t_addr tbl_addr(input t_idx p, input t_idx r);
        return t_addr'(p) * t_addr'(MAX_RES) + t_addr'(r);
    endfunction

endpackage

// ===== rtl/bankers_safety_check_core.sv =====
// Top level of the banker's safety check: item decode, tables and checker
// An item is taken every cycle while idle.
// A start item holds the input: a visit of an unfinished process goes through pick, then one table
// read and one compare per resource, then step; a skipped one through pick and step, over at
// most n passes of n processes; the results then leave one a cycle as the output drains.
// Reset is synchronous, active low: counts return to 1, work vector and finish flags clear.
module bankers_safety_check_core
    import bsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // process_index, resource_index, amount
    input  logic [1:0]            s_axis_tuser,   // opcode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // process_number, zero fill
    output logic [0:0]            m_axis_tuser,   // is_safe
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  bsc_pkg::t_cfg_idx     i_cfg_index,
    input  logic [4:0]            i_cfg_data
);

    t_cnt     r_num_procs;
    t_cnt     r_num_res;
    t_amount  r_avail [SLOTS];

    logic     accept;
    t_opcode  op;
    t_idx     p_idx;
    t_idx     r_idx;
    t_amount  amount;
    logic     in_range;
    logic     start;
    logic     idle;
    t_addr    waddr;
    t_rd_req  rd;
    t_amount  alloc_q;
    t_amount  claim_q;
    t_cnt     out_pnum;
    logic     out_safe;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign op       = t_opcode'(s_axis_tuser);
    assign p_idx    = s_axis_tdata[3:0];
    assign r_idx    = s_axis_tdata[7:4];
    assign amount   = s_axis_tdata[23:8];
    assign in_range = (int'(p_idx) < MAX_PROCS) && (int'(r_idx) < MAX_RES);
    assign start    = accept && (op == OP_START);
    assign waddr    = tbl_addr(p_idx, r_idx);
    assign s_axis_tready = idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_procs <= t_cnt'(1);
            r_num_res   <= t_cnt'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NUM_PROCS: r_num_procs <= i_cfg_data;
                CFG_NUM_RES:   r_num_res   <= i_cfg_data;
                default:       r_num_procs <= r_num_procs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (op == OP_AVAIL) && (int'(r_idx) < MAX_RES)) begin
            r_avail[r_idx] <= amount;
        end
    end

    bsc_table_ram #(
        .DEPTH (TBL_DEPTH),
        .WIDTH (AMT_W)
    ) u_alloc_ram (
        .i_clk   (i_clk),
        .i_we    (accept && (op == OP_ALLOC) && in_range),
        .i_waddr (waddr),
        .i_wdata (amount),
        .i_re    (rd.en),
        .i_raddr (rd.addr),
        .o_rdata (alloc_q)
    );

    bsc_table_ram #(
        .DEPTH (TBL_DEPTH),
        .WIDTH (AMT_W)
    ) u_claim_ram (
        .i_clk   (i_clk),
        .i_we    (accept && (op == OP_CLAIM) && in_range),
        .i_waddr (waddr),
        .i_wdata (amount),
        .i_re    (rd.en),
        .i_raddr (rd.addr),
        .o_rdata (claim_q)
    );

    bsc_check_fsm u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_num_procs (r_num_procs),
        .i_num_res   (r_num_res),
        .i_avail     (r_avail),
        .i_alloc     (alloc_q),
        .i_claim     (claim_q),
        .o_rd        (rd),
        .o_idle      (idle),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_pnum  (out_pnum),
        .o_out_safe  (out_safe),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_pnum};
    assign m_axis_tuser = out_safe;

endmodule

// ===== rtl/bsc_table_ram.sv =====
// Simple dual-port RAM with registered read data
module bsc_table_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bsc_check_fsm.sv =====
// Safety check sequencer: work vector, finish flags and result register
`include "bankers_safety_check_core_defines.svh"
module bsc_check_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  bsc_pkg::t_cnt    i_num_procs,
    input  bsc_pkg::t_cnt    i_num_res,
    input  bsc_pkg::t_amount i_avail [bsc_pkg::SLOTS],
    input  bsc_pkg::t_amount i_alloc,
    input  bsc_pkg::t_amount i_claim,
    output bsc_pkg::t_rd_req o_rd,
    output logic             o_idle,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output bsc_pkg::t_cnt    o_out_pnum,
    output logic             o_out_safe,
    output logic             o_out_last
);
    import bsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_READ,
        S_CHECK,
        S_STEP,
        S_EMIT
    } t_state;

    t_state           r_state, n_state;
    t_idx             r_i, n_i;
    t_idx             r_j, n_j;
    logic             r_progress, n_progress;
    logic [SLOTS-1:0] r_flags, n_flags;
    t_cnt             r_count, n_count;
    t_work            r_work [SLOTS];
    t_work            n_work [SLOTS];
    t_work            r_sum [SLOTS];
    t_work            n_sum [SLOTS];
    t_idx             r_seq [SLOTS];
    t_idx             n_seq [SLOTS];
    logic             r_emit_safe, n_emit_safe;
    logic             r_out_valid, n_out_valid;
    t_cnt             r_out_pnum, n_out_pnum;
    logic             r_out_safe, n_out_safe;
    logic             r_out_last, n_out_last;

    t_cnt             n_eff;
    t_cnt             m_eff;
    logic             i_last;
    logic             j_last;
    logic [WORK_W:0]  have;
    logic             fits_one;
    logic             slot_free;

    always_comb begin
        n_eff     = clamp_count(i_num_procs, PROC_LIMIT);
        m_eff     = clamp_count(i_num_res, RES_LIMIT);
        i_last    = ({1'b0, r_i} == (n_eff - t_cnt'(1)));
        j_last    = ({1'b0, r_j} == (m_eff - t_cnt'(1)));
        have      = {1'b0, r_work[r_j]} + (WORK_W+1)'(i_alloc);
        fits_one  = (have >= (WORK_W+1)'(i_claim));
        slot_free = !r_out_valid || i_out_ready;

        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_progress  = r_progress;
        n_flags     = r_flags;
        n_count     = r_count;
        n_work      = r_work;
        n_sum       = r_sum;
        n_seq       = r_seq;
        n_emit_safe = r_emit_safe;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_pnum  = r_out_pnum;
        n_out_safe  = r_out_safe;
        n_out_last  = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    for (int k = 0; k < SLOTS; k++) begin
                        n_work[k] = WORK_W'(i_avail[k]);
                    end
                    n_flags    = '0;
                    n_count    = '0;
                    n_i        = '0;
                    n_progress = 1'b0;
                    n_state    = S_PICK;
                end
            end
            S_PICK: begin
                if (r_flags[r_i]) begin
                    n_state = S_STEP;
                end else begin
                    n_j     = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_sum[r_j] = have[WORK_W-1:0];
                if (!fits_one) begin
                    n_state = S_STEP;
                end else if (j_last) begin
                    for (int k = 0; k < SLOTS; k++) begin
                        n_work[k] = r_sum[k];
                    end
                    n_work[r_j]    = have[WORK_W-1:0];
                    n_flags[r_i]   = 1'b1;
                    n_count        = r_count + t_cnt'(1);
                    n_progress     = 1'b1;
                    n_seq[r_count[IDX_W-1:0]] = r_i;
                    if ((r_count + t_cnt'(1)) == n_eff) begin
                        n_i         = '0;
                        n_emit_safe = 1'b1;
                        n_state     = S_EMIT;
                    end else begin
                        n_state = S_STEP;
                    end
                end else begin
                    n_j     = r_j + t_idx'(1);
                    n_state = S_READ;
                end
            end
            S_STEP: begin
                if (i_last) begin
                    if (!r_progress) begin
                        n_emit_safe = 1'b0;
                        n_state     = S_EMIT;
                    end else begin
                        n_i        = '0;
                        n_progress = 1'b0;
                        n_state    = S_PICK;
                    end
                end else begin
                    n_i     = r_i + t_idx'(1);
                    n_state = S_PICK;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if (r_emit_safe) begin
                        n_out_pnum = t_cnt'(r_seq[r_i]) + t_cnt'(1);
                        n_out_safe = 1'b1;
                        n_out_last = i_last;
                        if (i_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_i = r_i + t_idx'(1);
                        end
                    end else begin
                        n_out_pnum = '0;
                        n_out_safe = 1'b0;
                        n_out_last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_progress  <= 1'b0;
            r_flags     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_work[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_progress  <= n_progress;
            r_flags     <= n_flags;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_work      <= n_work;
        end
        r_sum       <= n_sum;
        r_seq       <= n_seq;
        r_emit_safe <= n_emit_safe;
        r_out_pnum  <= n_out_pnum;
        r_out_safe  <= n_out_safe;
        r_out_last  <= n_out_last;
    end

    assign o_rd.en     = (r_state == S_READ);
    assign o_rd.addr   = tbl_addr(r_i, r_j);
    assign o_idle      = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_pnum  = r_out_pnum;
    assign o_out_safe  = r_out_safe;
    assign o_out_last  = r_out_last;

    `BSC_ASSERT_IMPL(a_count_matches_flags, i_clk, i_rst_n, 1'b1, ($countones(r_flags) == r_count))
    `BSC_ASSERT_IMPL(a_unsafe_is_final, i_clk, i_rst_n, (r_out_valid && !r_out_safe), (r_out_last && (r_out_pnum == '0)))
    `BSC_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, ((r_state == S_IDLE) && i_start), ((r_flags == '0) && (r_count == '0) && (r_state == S_PICK)))

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for the banker's safety check core: table loads, check runs, safe sequences and unsafe verdicts
module tb;
    import bsc_pkg::*;

    localparam int IDLE_PCT    = 34;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        t_opcode     op;
        logic [3:0]  pidx;
        logic [3:0]  ridx;
        logic [15:0] amt;
    } t_item;

    typedef struct packed {
        logic [4:0] pnum;
        logic       is_safe;
        logic       is_last;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = OP_ALLOC;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we      = 1'b0;
    t_cfg_idx    i_cfg_index   = CFG_NUM_PROCS;
    logic [4:0]  i_cfg_data    = '0;

    bankers_safety_check_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor state
    logic [15:0] alloc_tbl [MAX_PROCS][MAX_RES];
    logic [15:0] claim_tbl [MAX_PROCS][MAX_RES];
    logic [15:0] avail_ld  [MAX_RES];
    logic [4:0]  cfg_procs = 5'd1;
    logic [4:0]  cfg_res   = 5'd1;

    // entries already loaded, so that no check reads an unwritten one
    bit alloc_known [MAX_PROCS][MAX_RES];
    bit claim_known [MAX_PROCS][MAX_RES];
    bit avail_known [MAX_RES];

    t_item  item_queue [$];
    t_grant expected_sequence [$];
    t_item  bus_item;
    t_grant got, want;

    int unsigned items_pushed   = 0;
    int unsigned items_accepted = 0;
    int unsigned checks_run     = 0;
    int unsigned results_seen   = 0;
    int unsigned unsafe_seen    = 0;
    int unsigned errors         = 0;
    int unsigned stall_cycles   = 0;
    int unsigned lim_p, lim_r;
    bit          in_taken  = 1'b0;
    bit          no_idle   = 1'b0;

    function automatic int unsigned limit_count(input logic [4:0] v, input int unsigned lim);
        if (v == 5'd0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    task automatic run_safety_check();
        int unsigned n, m, i, j, done_cnt, have, cnt;
        logic [20:0] work [MAX_RES];
        logic [15:0] done_mask;
        logic [4:0]  order [MAX_PROCS];
        bit          progress, fits, stuck;
        n = limit_count(cfg_procs, PROC_LIMIT);
        m = limit_count(cfg_res, RES_LIMIT);
        for (j = 0; j < m; j++) work[j] = {5'd0, avail_ld[j]};
        done_mask = '0;
        done_cnt  = 0;
        cnt       = 0;
        stuck     = 1'b0;
        while (done_cnt < n && !stuck) begin
            progress = 1'b0;
            for (i = 0; i < n; i++) begin
                if (!done_mask[i]) begin
                    fits = 1'b1;
                    for (j = 0; j < m && fits; j++) begin
                        have = work[j] + alloc_tbl[i][j];
                        if (have < claim_tbl[i][j]) fits = 1'b0;
                    end
                    if (fits) begin
                        for (j = 0; j < m; j++) work[j] = work[j] + alloc_tbl[i][j];
                        done_mask[i] = 1'b1;
                        done_cnt++;
                        order[cnt] = 5'(i + 1);
                        cnt++;
                        progress = 1'b1;
                    end
                end
            end
            if (!progress) stuck = 1'b1;
        end
        checks_run++;
        if (stuck) begin
            expected_sequence.push_back(t_grant'{5'd0, 1'b0, 1'b1});
        end else begin
            for (i = 0; i < cnt; i++)
                expected_sequence.push_back(t_grant'{order[i], 1'b1, i == cnt - 1});
        end
    endtask

    task automatic apply_item(input t_item it);
        case (it.op)
            OP_ALLOC: alloc_tbl[it.pidx][it.ridx] = it.amt;
            OP_CLAIM: claim_tbl[it.pidx][it.ridx] = it.amt;
            OP_AVAIL: avail_ld[it.ridx] = it.amt;
            OP_START: run_safety_check();
            default: ;
        endcase
    endtask

    task automatic send(input t_opcode op, input int p, input int r, input int unsigned a);
        item_queue.push_back(t_item'{op, 4'(p), 4'(r), 16'(a)});
        items_pushed++;
        case (op)
            OP_ALLOC: alloc_known[p][r] = 1'b1;
            OP_CLAIM: claim_known[p][r] = 1'b1;
            OP_AVAIL: avail_known[r] = 1'b1;
            default: ;
        endcase
    endtask

    // claim at or below allocation gives a need of zero or below
    task automatic post_entry(input int p, input int r, input bit wide);
        int unsigned a, c;
        a = wide ? $urandom_range(0, 65535) : $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) begin
            c = $urandom_range(0, a);
        end else begin
            c = a + $urandom_range(0, wide ? 1000 : 3);
            if (c > 65535) c = 65535;
        end
        send(OP_ALLOC, p, r, a);
        send(OP_CLAIM, p, r, c);
    endtask

    task automatic post_avail(input int r, input bit wide);
        send(OP_AVAIL, $urandom_range(0, 15), r,
             wide ? $urandom_range(32768, 65535) : $urandom_range(0, 5));
    endtask

    task automatic start_check();
        int unsigned n, m, p, r;
        n = limit_count(cfg_procs, PROC_LIMIT);
        m = limit_count(cfg_res, RES_LIMIT);
        for (p = 0; p < n; p++)
            for (r = 0; r < m; r++)
                if (!alloc_known[p][r] || !claim_known[p][r]) post_entry(p, r, 1'b0);
        for (r = 0; r < m; r++)
            if (!avail_known[r]) post_avail(r, 1'b0);
        send(OP_START, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 65535));
    endtask

    task automatic drain();
        while (items_accepted != items_pushed || expected_sequence.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_limits(input logic [4:0] np, input logic [4:0] nr);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_NUM_PROCS;
        i_cfg_data  <= np;
        cfg_procs    = np;
        @(negedge i_clk);
        i_cfg_index <= CFG_NUM_RES;
        i_cfg_data  <= nr;
        cfg_res      = nr;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [4:0] pick_count();
        case ($urandom_range(0, 9))
            0: return 5'd0;
            1: return 5'd31;
            2: return 5'd16;
            3: return 5'd17;
            default: return 5'($urandom_range(1, 5));
        endcase
    endfunction

    function automatic logic [4:0] pick_res_count();
        case ($urandom_range(0, 4))
            0: return 5'd0;
            default: return 5'($urandom_range(1, 2));
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // drive the input side and the result ready
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (!s_axis_tvalid || in_taken) begin
                if (item_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    bus_item = item_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {bus_item.amt, bus_item.ridx, bus_item.pidx};
                    s_axis_tuser  <= bus_item.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            in_taken = 1'b0;
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // accept items, compare results, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_item(bus_item);
                items_accepted++;
                in_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_grant'{m_axis_tdata[4:0], m_axis_tuser[0], m_axis_tlast};
                if (expected_sequence.size() == 0) begin
                    $display("%0t: unexpected result process=%0d safe=%0d last=%0d",
                             $time, got.pnum, got.is_safe, got.is_last);
                    errors++;
                end else begin
                    want = expected_sequence.pop_front();
                    results_seen++;
                    if (!want.is_safe) unsafe_seen++;
                    if (got !== want) begin
                        $display("%0t: mismatch: expected process=%0d safe=%0d last=%0d, got process=%0d safe=%0d last=%0d",
                                 $time, want.pnum, want.is_safe, want.is_last,
                                 got.pnum, got.is_safe, got.is_last);
                        errors++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send(OP_ALLOC, 0, 0, 0);
        send(OP_CLAIM, 0, 0, 0);
        send(OP_AVAIL, 0, 0, 0);
        start_check();
        send(OP_CLAIM, 0, 0, 5);
        start_check();
        send(OP_ALLOC, 0, 0, 16'hffff);
        send(OP_CLAIM, 0, 0, 0);
        send(OP_ALLOC, 15, 15, 16'hffff);
        send(OP_CLAIM, 15, 15, 0);
        start_check();
        send(OP_ALLOC, 0, 0, 0);
        send(OP_CLAIM, 0, 0, 16'hffff);
        send(OP_AVAIL, 15, 0, 16'hffff);
        start_check();
        send(OP_AVAIL, 0, 0, 16'hfffe);
        start_check();
        start_check();

        set_limits(5'd0, 5'd31);
        start_check();

        // every process on one resource with wide values, no idling on either side
        no_idle = 1'b1;
        set_limits(5'd31, 5'd1);
        for (int p = 0; p < MAX_PROCS; p++) post_entry(p, 0, 1'b1);
        post_avail(0, 1'b1);
        start_check();
        drain();
        no_idle = 1'b0;

        // third process frees enough for the first two on the second pass
        set_limits(5'd3, 5'd1);
        send(OP_ALLOC, 0, 0, 0);
        send(OP_CLAIM, 0, 0, 3);
        send(OP_ALLOC, 1, 0, 1);
        send(OP_CLAIM, 1, 0, 3);
        send(OP_ALLOC, 2, 0, 2);
        send(OP_CLAIM, 2, 0, 2);
        send(OP_AVAIL, 0, 0, 1);
        start_check();

        while (items_pushed < 120) begin
            if ($urandom_range(0, 3) == 0) set_limits(pick_count(), pick_res_count());
            lim_p = limit_count(cfg_procs, PROC_LIMIT);
            lim_r = limit_count(cfg_res, RES_LIMIT);
            repeat ($urandom_range(0, 4)) begin
                case ($urandom_range(0, 5))
                    0: send(t_opcode'(2'($urandom_range(0, 2))), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 65535));
                    1: post_avail($urandom_range(0, lim_r - 1), 1'b0);
                    default: post_entry($urandom_range(0, lim_p - 1),
                                        $urandom_range(0, lim_r - 1), 1'b0);
                endcase
            end
            if ($urandom_range(0, 5) == 0) drain();
            start_check();
        end

        drain();
        repeat (20) @(negedge i_clk);
        $display("Sent %0d items, ran %0d safety checks under changing process and resource counts;",
                 items_accepted, checks_run);
        $display("compared %0d results, %0d of them unsafe verdicts.", results_seen, unsafe_seen);
        if (errors == 0 && expected_sequence.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
